FILE: src/mrrb_pkg.sv
// ----------------------------------------------------------------------------
// Multi-reader ring buffer package
// Shared types, field widths, operation codes and a helper function.
// ----------------------------------------------------------------------------
package mrrb_pkg;

    localparam int MODE_W   = 3;
    localparam int RDR_W    = 3;
    localparam int DATA_W   = 8;
    localparam int CNT_W    = 11;
    localparam int OUT_W    = 11;
    localparam int RS_W     = 12;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int MIN_RING = 1280;

    localparam logic [RS_W-1:0] RING_SIZE_RST = 12'd2048;
    localparam logic            REG_RING_SIZE = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE     = 3'd0,
        MODE_READ      = 3'd1,
        MODE_DISCARD   = 3'd2,
        MODE_CREATE    = 3'd3,
        MODE_REMOVE    = 3'd4,
        MODE_FLUSH     = 3'd5,
        MODE_FLUSH_ALL = 3'd6,
        MODE_NOP       = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [RDR_W-1:0]  reader;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0]  moved;
        logic [DATA_W-1:0] read_byte;
        logic [OUT_W-1:0]  reader_fill;
        logic [OUT_W-1:0]  free_space;
        logic              last_out;
    } t_out;

    typedef struct packed {
        logic            wr;
        logic [RS_W-1:0] wsize;
        logic [RS_W-1:0] size;
    } t_cfg;

    function automatic int ring_len(input logic [RS_W-1:0] size, input int depth);
        int s;
        s = int'(size);
        if (s < MIN_RING) s = MIN_RING;
        if (s > depth) s = depth;
        return s;
    endfunction

endpackage

FILE: src/mrrb_mem.sv
// ----------------------------------------------------------------------------
// Multi-reader ring buffer memory
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module mrrb_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mrrb_cfg.sv
// ----------------------------------------------------------------------------
// Multi-reader ring buffer configuration registers
// APB-style register port holding the ring size register.
// ----------------------------------------------------------------------------
module mrrb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrrb_pkg::CFG_AW-1:0] paddr,
    input  logic [mrrb_pkg::CFG_DW-1:0] pwdata,
    output logic [mrrb_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output mrrb_pkg::t_cfg              o_cfg
);

    import mrrb_pkg::*;

    logic [RS_W-1:0] r_ring_size;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RING_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RING_SIZE_RST;
        end else if (wr_en) begin
            r_ring_size <= pwdata[RS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RING_SIZE) begin
            prdata = CFG_DW'(r_ring_size);
        end
    end

    assign o_cfg.wr    = wr_en;
    assign o_cfg.wsize = pwdata[RS_W-1:0];
    assign o_cfg.size  = r_ring_size;

endmodule

FILE: src/multi_reader_ring_buffer.sv
// ----------------------------------------------------------------------------
// Multi-reader ring buffer
// Byte ring with one writer and up to READERS readers, each with its own
// read position; every operation returns one status transfer.
// ----------------------------------------------------------------------------
// Operations arrive on the input channel (i_valid/o_ready, payload i_item)
// and each one produces exactly one result on the output channel
// (o_valid/i_ready, payload o_result). The ring size register sits on the
// APB-style port; the user must write it only while the block is idle (not
// enforced by the block); a write zeroes the write and all read positions.
// One operation occupies the block from its input transfer until its result
// is loaded: it takes the transfer, reads, modifies and writes the named
// reader's position, sweeps the read-position memory for the most-lagging
// reader, and loads the output register. No new operation is taken before
// then. The sweep through the position memory, one entry per cycle, sets
// the rate.
// A new input transfer is taken while a result still waits in the output
// register; if the receiver stalls, the next result holds in its final
// cycle until the output register is free. Reset clears the positions and
// the reader set; stored bytes are not cleared.
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer #(
    parameter int DEPTH   = 2048,
    parameter int READERS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  mrrb_pkg::t_in               i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output mrrb_pkg::t_out              o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrrb_pkg::CFG_AW-1:0] paddr,
    input  logic [mrrb_pkg::CFG_DW-1:0] pwdata,
    output logic [mrrb_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    import mrrb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CW = $clog2(READERS + 1);

    t_cfg            cfg;
    logic [SW-1:0]   sz;

    t_state          r_state, n_state;
    t_in             r_item, n_item;
    logic [PW-1:0]   r_wp, n_wp;
    logic [READERS-1:0] r_live, n_live;
    logic [READERS-1:0] r_stale, n_stale;
    logic [PW-1:0]   r_free, n_free;
    logic [PW-1:0]   r_used, n_used;
    logic [PW-1:0]   r_fill, n_fill;
    logic [OUT_W-1:0] r_moved, n_moved;
    logic            r_rd, n_rd;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    logic            ring_we, ring_re;
    logic [PW-1:0]   ring_waddr, ring_raddr;
    logic [DATA_W-1:0] ring_wdata, ring_q;
    logic            pos_we, pos_re;
    logic [RW-1:0]   pos_waddr, pos_raddr;
    logic [PW-1:0]   pos_wdata, pos_q;

    logic            slot_ok;
    logic [RW-1:0]   rsel;

    function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] wp,
                                              input logic [PW-1:0] rp,
                                              input logic [SW-1:0] s);
        logic [SW:0] t;
        t = (SW+1)'(wp) - (SW+1)'(rp);
        if (wp < rp) t = t + (SW+1)'(s);
        return PW'(t);
    endfunction

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos,
                                               input logic [PW-1:0] inc,
                                               input logic [SW-1:0] s);
        logic [SW:0] t;
        t = (SW+1)'(pos) + (SW+1)'(inc);
        if (t >= (SW+1)'(s)) t = t - (SW+1)'(s);
        return PW'(t);
    endfunction

    mrrb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mrrb_mem #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ring_mem (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_q)
    );

    mrrb_mem #(
        .WIDTH (PW),
        .DEPTH (READERS),
        .AW    (RW)
    ) u_pos_mem (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_q)
    );

    assign sz      = SW'(ring_len(cfg.size, DEPTH));
    assign slot_ok = (int'(r_item.reader) < READERS);
    assign rsel    = RW'(r_item.reader);

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_live      <= '0;
            r_stale     <= '1;
            r_free      <= PW'(ring_len(RING_SIZE_RST, DEPTH) - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_live      <= n_live;
            r_stale     <= n_stale;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_used  <= n_used;
        r_fill  <= n_fill;
        r_moved <= n_moved;
        r_rd    <= n_rd;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    always_comb begin
        logic [PW-1:0] rp_cur;
        logic          live_cur;
        logic [PW-1:0] f_cur;
        logic [PW-1:0] cnt_ext;
        logic [PW-1:0] n_dis;
        logic [RW-1:0] pidx;
        logic          live_p;
        logic [PW-1:0] rp_p;
        logic [PW-1:0] fill_p;

        n_state     = r_state;
        n_item      = r_item;
        n_wp        = r_wp;
        n_live      = r_live;
        n_stale     = r_stale;
        n_free      = r_free;
        n_used      = r_used;
        n_fill      = r_fill;
        n_moved     = r_moved;
        n_rd        = r_rd;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_waddr = r_wp;
        ring_raddr = '0;
        ring_wdata = r_item.data;
        pos_we     = 1'b0;
        pos_re     = 1'b0;
        pos_waddr  = rsel;
        pos_raddr  = '0;
        pos_wdata  = '0;

        rp_cur   = r_stale[rsel] ? '0 : pos_q;
        live_cur = slot_ok && r_live[rsel];
        f_cur    = fill_of(r_wp, rp_cur, sz);
        cnt_ext  = PW'(r_item.count);
        n_dis    = (cnt_ext < f_cur) ? cnt_ext : f_cur;
        pidx     = RW'(r_idx - 1'b1);
        live_p   = r_live[pidx];
        rp_p     = r_stale[pidx] ? '0 : pos_q;
        fill_p   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_item    = i_item;
                    pos_re    = 1'b1;
                    pos_raddr = RW'(i_item.reader);
                    n_moved   = '0;
                    n_rd      = 1'b0;
                    n_state   = ST_OP;
                end
            end
            ST_OP: begin
                unique case (r_item.mode)
                    MODE_WRITE: begin
                        if (r_free != '0) begin
                            ring_we = 1'b1;
                            n_wp    = wrap_add(r_wp, PW'(1), sz);
                            n_moved = OUT_W'(1);
                        end
                    end
                    MODE_READ: begin
                        if (live_cur && f_cur != '0) begin
                            ring_re       = 1'b1;
                            ring_raddr    = rp_cur;
                            pos_we        = 1'b1;
                            pos_wdata     = wrap_add(rp_cur, PW'(1), sz);
                            n_stale[rsel] = 1'b0;
                            n_moved       = OUT_W'(1);
                            n_rd          = 1'b1;
                        end
                    end
                    MODE_DISCARD: begin
                        if (live_cur) begin
                            pos_we        = 1'b1;
                            pos_wdata     = wrap_add(rp_cur, n_dis, sz);
                            n_stale[rsel] = 1'b0;
                            n_moved       = OUT_W'(n_dis);
                        end
                    end
                    MODE_CREATE: begin
                        if (slot_ok && !r_live[rsel]) begin
                            n_live[rsel]  = 1'b1;
                            pos_we        = 1'b1;
                            pos_wdata     = r_wp;
                            n_stale[rsel] = 1'b0;
                        end
                    end
                    MODE_REMOVE: begin
                        if (slot_ok) begin
                            n_live[rsel]  = 1'b0;
                            pos_we        = 1'b1;
                            pos_wdata     = '0;
                            n_stale[rsel] = 1'b0;
                        end
                    end
                    MODE_FLUSH: begin
                        if (live_cur) begin
                            pos_we        = 1'b1;
                            pos_wdata     = r_wp;
                            n_stale[rsel] = 1'b0;
                        end
                    end
                    MODE_FLUSH_ALL, MODE_NOP: begin
                    end
                endcase
                n_idx   = '0;
                n_used  = '0;
                n_fill  = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (int'(r_idx) < READERS) begin
                    pos_re    = 1'b1;
                    pos_raddr = r_idx[RW-1:0];
                end
                if (r_idx != '0) begin
                    if (r_item.mode == MODE_FLUSH_ALL && live_p) begin
                        pos_we        = 1'b1;
                        pos_waddr     = pidx;
                        pos_wdata     = r_wp;
                        n_stale[pidx] = 1'b0;
                        rp_p          = r_wp;
                    end
                    if (live_p) begin
                        fill_p = fill_of(r_wp, rp_p, sz);
                    end
                    if (fill_p > r_used) begin
                        n_used = fill_p;
                    end
                    if (slot_ok && pidx == rsel) begin
                        n_fill = fill_p;
                    end
                end
                if (r_idx == CW'(READERS)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_free            = PW'(sz - 1 - r_used);
                    n_out.moved       = r_moved;
                    n_out.read_byte   = r_rd ? ring_q : '0;
                    n_out.reader_fill = OUT_W'(r_fill);
                    n_out.free_space  = OUT_W'(PW'(sz - 1 - r_used));
                    n_out.last_out    = r_item.last;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
        endcase

        if (cfg.wr) begin
            n_wp    = '0;
            n_stale = '1;
            n_free  = PW'(ring_len(cfg.wsize, DEPTH) - 1);
        end
    end

    a_ring_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> (r_state == ST_OP && r_free != '0))
        else $error("ring byte written with no free space");

    a_pos_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pos_we && pos_re && pos_waddr == pos_raddr))
        else $error("position memory read and written at the same entry");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished operation did not reach the output register");

    a_scan_follows_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OP) |=> (r_state == ST_SCAN && r_idx == '0 && r_used == '0))
        else $error("position sweep did not start cleanly");

endmodule

FILE: tb/tb_multi_reader_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-reader ring buffer
// Drives operations through the input channel and the ring size register,
// predicts every status transfer from a behavioral copy of the ring and the
// reader positions, and compares each returned status field by field.
// ----------------------------------------------------------------------------
module tb_multi_reader_ring_buffer;
    import mrrb_pkg::*;

    localparam int DEPTH       = 2048;
    localparam int READERS     = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_AW-1:0] RING_SIZE_ADDR = CFG_AW'(4 * int'(REG_RING_SIZE));

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    t_in               i_item  = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_out              o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [CFG_DW-1:0] pwdata  = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    logic [7:0]        ring_mem [DEPTH];
    logic [OUT_W-1:0]  wr_pos_m;
    logic [OUT_W-1:0]  rd_pos_m [READERS];
    logic              live_m   [READERS];
    logic [RS_W-1:0]   ring_size_m;

    t_out pending_status [$];

    int  ops_sent       = 0;
    int  status_checked = 0;
    int  bad_status     = 0;
    int  writes_refused = 0;
    int  size_writes    = 0;
    int  quiet_cycles   = 0;
    int  rx_hold_req    = 0;
    int  rx_hold_left   = 0;
    int  rx_stall_left  = 0;
    bit  tx_gaps_on     = 1'b1;
    bit  rx_stalls_on   = 1'b1;

    multi_reader_ring_buffer #(
        .DEPTH   (DEPTH),
        .READERS (READERS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ring_span();
        int s;
        s = int'(ring_size_m);
        if (s < MIN_RING) s = MIN_RING;
        if (s > DEPTH) s = DEPTH;
        return s;
    endfunction

    function automatic int pending_bytes(input logic [RDR_W-1:0] r, input int sz);
        if (!live_m[r]) return 0;
        return (int'(wr_pos_m) + sz - int'(rd_pos_m[r])) % sz;
    endfunction

    // The writer is held back by the reader with the most bytes pending.
    function automatic int free_bytes(input int sz);
        int worst;
        worst = 0;
        for (int i = 0; i < READERS; i++) begin
            if (pending_bytes(RDR_W'(i), sz) > worst) worst = pending_bytes(RDR_W'(i), sz);
        end
        return sz - 1 - worst;
    endfunction

    function automatic t_out predict_step(input t_in op);
        t_out res;
        int   sz;
        int   n;
        sz = ring_span();
        res = '0;
        res.last_out = op.last;
        unique case (t_mode'(op.mode))
            MODE_WRITE: begin
                if (free_bytes(sz) > 0) begin
                    ring_mem[wr_pos_m] = op.data;
                    wr_pos_m = OUT_W'((int'(wr_pos_m) + 1) % sz);
                    res.moved = OUT_W'(1);
                end else begin
                    writes_refused++;
                end
            end
            MODE_READ: begin
                if (pending_bytes(op.reader, sz) > 0) begin
                    res.read_byte = ring_mem[rd_pos_m[op.reader]];
                    rd_pos_m[op.reader] = OUT_W'((int'(rd_pos_m[op.reader]) + 1) % sz);
                    res.moved = OUT_W'(1);
                end
            end
            MODE_DISCARD: begin
                if (live_m[op.reader]) begin
                    n = pending_bytes(op.reader, sz);
                    if (int'(op.count) < n) n = int'(op.count);
                    rd_pos_m[op.reader] = OUT_W'((int'(rd_pos_m[op.reader]) + n) % sz);
                    res.moved = OUT_W'(n);
                end
            end
            MODE_CREATE: begin
                if (!live_m[op.reader]) begin
                    live_m[op.reader] = 1'b1;
                    rd_pos_m[op.reader] = wr_pos_m;
                end
            end
            MODE_REMOVE: begin
                live_m[op.reader] = 1'b0;
                rd_pos_m[op.reader] = '0;
            end
            MODE_FLUSH: begin
                if (live_m[op.reader]) rd_pos_m[op.reader] = wr_pos_m;
            end
            MODE_FLUSH_ALL: begin
                for (int i = 0; i < READERS; i++) begin
                    if (live_m[i]) rd_pos_m[i] = wr_pos_m;
                end
            end
            default: begin
            end
        endcase
        res.reader_fill = OUT_W'(pending_bytes(op.reader, sz));
        res.free_space  = OUT_W'(free_bytes(sz));
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 75) return $urandom_range(8, 1);
        if (p < 95) return $urandom_range(20, 9);
        return $urandom_range(80, 30);
    endfunction

    function automatic t_in make_op(input t_mode mode, input logic [RDR_W-1:0] reader,
                                    input logic [DATA_W-1:0] data,
                                    input logic [CNT_W-1:0] count, input logic last);
        t_in op;
        op.mode   = mode;
        op.reader = reader;
        op.data   = data;
        op.count  = count;
        op.last   = last;
        return op;
    endfunction

    // Mostly operations on live readers, with some traffic to absent slots.
    function automatic t_in rand_op();
        t_in op;
        int  pick;
        int  live_ids [$];
        for (int i = 0; i < READERS; i++) begin
            if (live_m[i]) live_ids.push_back(i);
        end
        op.data   = DATA_W'($urandom);
        op.count  = CNT_W'($urandom);
        op.last   = 1'($urandom);
        op.reader = RDR_W'($urandom);
        pick = $urandom_range(99);
        if (live_ids.size() == 0 && pick < 70) op.mode = MODE_CREATE;
        else if (pick < 48) op.mode = MODE_WRITE;
        else if (pick < 70) op.mode = MODE_READ;
        else if (pick < 78) op.mode = MODE_DISCARD;
        else if (pick < 84) op.mode = MODE_CREATE;
        else if (pick < 88) op.mode = MODE_REMOVE;
        else if (pick < 93) op.mode = MODE_FLUSH;
        else if (pick < 95) op.mode = MODE_FLUSH_ALL;
        else op.mode = MODE_NOP;
        if ((op.mode == MODE_READ || op.mode == MODE_DISCARD || op.mode == MODE_FLUSH)
                && live_ids.size() != 0 && $urandom_range(9) != 0) begin
            op.reader = RDR_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
        end
        if (op.mode == MODE_DISCARD && $urandom_range(3) != 0) begin
            op.count = CNT_W'($urandom_range(16));
        end
        return op;
    endfunction

    task automatic send_op(input t_in op);
        i_item  <= op;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_status.push_back(predict_step(op));
        ops_sent++;
        if (tx_gaps_on && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (READERS + 8) @(posedge i_clk);
    endtask

    // Positions return to zero on every ring size write; stored bytes stay.
    task automatic write_ring_size(input logic [RS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RING_SIZE_ADDR;
        pwdata  <= CFG_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_size_m = value;
        wr_pos_m = '0;
        for (int i = 0; i < READERS; i++) rd_pos_m[i] = '0;
        size_writes++;
    endtask

    task automatic test_directed_ops();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_op(make_op(MODE_NOP,       3'd7, 8'h00, 11'd0,    1'b1));
        send_op(make_op(MODE_READ,      3'd0, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_DISCARD,   3'd5, 8'h00, 11'd2047, 1'b0));
        send_op(make_op(MODE_FLUSH,     3'd3, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_REMOVE,    3'd6, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_WRITE,     3'd0, 8'hFF, 11'd0,    1'b1));
        send_op(make_op(MODE_CREATE,    3'd0, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_CREATE,    3'd7, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_CREATE,    3'd0, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_WRITE,     3'd0, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_WRITE,     3'd7, 8'hFF, 11'd2047, 1'b0));
        send_op(make_op(MODE_WRITE,     3'd0, 8'h5A, 11'd0,    1'b1));
        send_op(make_op(MODE_READ,      3'd0, 8'hFF, 11'd2047, 1'b0));
        send_op(make_op(MODE_READ,      3'd7, 8'h00, 11'd0,    1'b1));
        send_op(make_op(MODE_DISCARD,   3'd0, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_DISCARD,   3'd0, 8'h00, 11'd2047, 1'b0));
        send_op(make_op(MODE_READ,      3'd0, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_WRITE,     3'd0, 8'hA5, 11'd0,    1'b1));
        send_op(make_op(MODE_FLUSH,     3'd7, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_FLUSH_ALL, 3'd0, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_WRITE,     3'd0, 8'h3C, 11'd0,    1'b0));
        send_op(make_op(MODE_REMOVE,    3'd7, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_READ,      3'd7, 8'h00, 11'd0,    1'b0));
        send_op(make_op(MODE_NOP,       3'd0, 8'hFF, 11'd2047, 1'b0));
    endtask

    // Reader 0 lags until the ring is full, then the write position wraps
    // while the lagging reader holds the numerically larger position.
    task automatic test_fill_to_full(input logic [RS_W-1:0] size_val, input bit idle_on);
        int sz;
        wait_idle();
        tx_gaps_on   = idle_on;
        rx_stalls_on = idle_on;
        write_ring_size(size_val);
        sz = ring_span();
        send_op(make_op(MODE_CREATE, 3'd0, 8'h00, 11'd0, 1'b0));
        send_op(make_op(MODE_CREATE, 3'd2, 8'h00, 11'd0, 1'b0));
        for (int i = 0; i < sz - 1; i++) begin
            send_op(make_op(MODE_WRITE, 3'd0, DATA_W'($urandom), 11'd0, 1'($urandom)));
            if (i % 16 == 15) send_op(make_op(MODE_READ, 3'd2, 8'h00, 11'd0, 1'b0));
        end
        repeat (3) send_op(make_op(MODE_WRITE, 3'd1, DATA_W'($urandom), 11'd0, 1'b1));
        send_op(make_op(MODE_READ,  3'd0, 8'h00, 11'd0, 1'b0));
        send_op(make_op(MODE_WRITE, 3'd0, 8'hC3, 11'd0, 1'b0));
        send_op(make_op(MODE_WRITE, 3'd0, 8'h3C, 11'd0, 1'b0));
        send_op(make_op(MODE_DISCARD, 3'd0, 8'h00, 11'd2047, 1'b0));
        send_op(make_op(MODE_DISCARD, 3'd2, 8'h00, 11'd2047, 1'b0));
        for (int i = 0; i < 40; i++) begin
            send_op(make_op(MODE_WRITE, 3'd4, DATA_W'($urandom), 11'd0, 1'($urandom)));
            if (i % 2 == 1) send_op(make_op(MODE_READ, 3'd0, 8'h00, 11'd0, 1'b0));
        end
        send_op(make_op(MODE_DISCARD,   3'd2, 8'h00, 11'd5, 1'b0));
        send_op(make_op(MODE_FLUSH,     3'd0, 8'h00, 11'd0, 1'b0));
        send_op(make_op(MODE_FLUSH_ALL, 3'd2, 8'h00, 11'd0, 1'b1));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_ring_size(MIN_RING);
        send_op(make_op(MODE_CREATE, 3'd1, 8'h00, 11'd0, 1'b0));
        send_op(make_op(MODE_CREATE, 3'd4, 8'h00, 11'd0, 1'b0));
        rx_hold_req = HOLD_CYCLES;
        repeat (60) send_op(rand_op());
    endtask

    task automatic test_random_mix(input logic [RS_W-1:0] size_val, input int n_ops,
                                   input bit tx_idle, input bit rx_idle);
        wait_idle();
        tx_gaps_on   = tx_idle;
        rx_stalls_on = rx_idle;
        write_ring_size(size_val);
        repeat (n_ops) send_op(rand_op());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
            i_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(99) < 15) begin
            rx_stall_left = pick_gap() - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            status_checked++;
            if (pending_status.size() == 0) begin
                bad_status++;
                if (bad_status <= MAX_REPORTS) begin
                    $display("Extra status at %0t: moved=%0d byte=%02h fill=%0d free=%0d last=%0b",
                             $realtime, o_result.moved, o_result.read_byte,
                             o_result.reader_fill, o_result.free_space, o_result.last_out);
                end
            end else begin
                want = pending_status.pop_front();
                if (o_result.moved !== want.moved || o_result.read_byte !== want.read_byte
                        || o_result.reader_fill !== want.reader_fill
                        || o_result.free_space !== want.free_space
                        || o_result.last_out !== want.last_out) begin
                    bad_status++;
                    if (bad_status <= MAX_REPORTS) begin
                        $display("Status %0d differs at %0t:", status_checked, $realtime);
                        $display("  expected moved=%0d byte=%02h fill=%0d free=%0d last=%0b",
                                 want.moved, want.read_byte, want.reader_fill,
                                 want.free_space, want.last_out);
                        $display("  actual   moved=%0d byte=%02h fill=%0d free=%0d last=%0b",
                                 o_result.moved, o_result.read_byte, o_result.reader_fill,
                                 o_result.free_space, o_result.last_out);
                    end
                end
            end
        end
    end

    // The longest legal quiet stretch is the receiver hold of HOLD_CYCLES.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d statuses outstanding",
                     QUIET_LIMIT, pending_status.size());
            $display("multi_reader_ring_buffer: mismatch");
            $finish;
        end
    end

    initial begin
        logic [RS_W-1:0] odd_size;
        odd_size    = RS_W'($urandom_range(2047, 1281));
        ring_size_m = RING_SIZE_RST;
        wr_pos_m    = '0;
        for (int i = 0; i < READERS; i++) begin
            rd_pos_m[i] = '0;
            live_m[i]   = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_fill_to_full(12'd0, 1'b1);
        test_output_backpressure();
        test_random_mix(12'd4095, 70, 1'b1, 1'b1);
        test_random_mix(odd_size, 60, 1'b0, 1'b1);
        test_random_mix(RING_SIZE_RST, 60, 1'b1, 1'b0);

        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2 * (READERS + 4)) @(posedge i_clk);

        $display("Sent %0d operations and checked %0d statuses over %0d ring size settings,",
                 ops_sent, status_checked, size_writes);
        $display("including %0d writes refused on a full ring and one long receiver hold.",
                 writes_refused);
        if (bad_status == 0 && pending_status.size() == 0) begin
            $display("multi_reader_ring_buffer: match");
        end else begin
            $display("multi_reader_ring_buffer: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mrrb_pkg.sv
src/mrrb_mem.sv
src/mrrb_cfg.sv
src/multi_reader_ring_buffer.sv
tb/tb_multi_reader_ring_buffer.sv
